/* hdl/nsfc_pkg.sv */
// Shared widths, register codes and configuration types for the nearest-neighbor scaler.
`default_nettype none

package nsfc_pkg;

    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_DIM   = 4096;

    localparam int PROD_W = 2 * DIM_W;
    localparam int LEN_W  = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int NUM_W  = LEN_W + DIM_W;
    localparam int Q_W    = COORD_W;

    localparam logic [MODE_W-1:0] MODE_FIT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ZOOM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 3'd4;

    typedef enum logic [1:0] {
        AX_PLAIN,
        AX_LETTERBOX,
        AX_CROP
    } axis_kind_t;

    typedef struct packed {
        axis_kind_t         kind;
        logic [LEN_W-1:0]   offset;
        logic [LEN_W-1:0]   divisor;
        logic [DIM_W-1:0]   scale;
        logic [DIM_W-1:0]   limit;
    } axis_cfg_t;

    typedef struct packed {
        logic       enable;
        axis_cfg_t  ax_x;
        axis_cfg_t  ax_y;
    } frame_cfg_t;

endpackage

`default_nettype wire

/* hdl/nsfc_setup.sv */
// Configuration registers and the per-frame setup sequencer with its serial divider.
`default_nettype none

module nsfc_setup
    import nsfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output logic                 active,
    output frame_cfg_t           frame_cfg
);

    localparam int CNT_W = $clog2(PROD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CMP,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0]  src_width_reg;
    logic [DIM_W-1:0]  src_height_reg;
    logic [DIM_W-1:0]  dst_width_reg;
    logic [DIM_W-1:0]  dst_height_reg;
    logic [MODE_W-1:0] fit_mode_reg;

    logic [DIM_W-1:0]  sw_reg;
    logic [DIM_W-1:0]  sh_reg;
    logic [DIM_W-1:0]  dw_reg;
    logic [DIM_W-1:0]  dh_reg;
    logic [PROD_W-1:0] p1_reg;
    logic [PROD_W-1:0] p2_reg;
    logic              fill_width_reg;
    logic              enable_reg;
    logic [DIM_W-1:0]  den_reg;
    logic [DIM_W:0]    rem_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    frame_cfg_t        frame_cfg_reg;

    logic [DIM_W-1:0]  sw_c;
    logic [DIM_W-1:0]  sh_c;
    logic [DIM_W-1:0]  dw_c;
    logic [DIM_W-1:0]  dh_c;
    logic              wide;
    logic              fill_width_next;
    logic              enable_next;
    logic [DIM_W:0]    rem_shift;
    logic [DIM_W:0]    rem_next;
    logic [PROD_W-1:0] quo_next;
    logic [LEN_W-1:0]  len;
    frame_cfg_t        frame_cfg_next;
    logic              cfg_write;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign active    = (state_reg != ST_IDLE);
    assign frame_cfg = frame_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DIM_W'(640);
            src_height_reg <= DIM_W'(480);
            dst_width_reg  <= DIM_W'(640);
            dst_height_reg <= DIM_W'(480);
            fit_mode_reg   <= MODE_FIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                REG_FIT_MODE:   fit_mode_reg   <= cfg_data[MODE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        sw_c = clamp_dim(src_width_reg);
        sh_c = clamp_dim(src_height_reg);
        dw_c = clamp_dim(dst_width_reg);
        dh_c = clamp_dim(dst_height_reg);

        wide            = (p1_reg > p2_reg);
        fill_width_next = (fit_mode_reg == MODE_FIT) ? wide : !wide;
        enable_next     = ((fit_mode_reg == MODE_FIT) || (fit_mode_reg == MODE_ZOOM)) &&
                          (sw_reg != '0) && (sh_reg != '0) &&
                          (dw_reg != '0) && (dh_reg != '0);

        rem_shift = {rem_reg[DIM_W-1:0], quo_reg[PROD_W-1]};
        if (rem_shift >= {1'b0, den_reg})
        begin
            rem_next = rem_shift - {1'b0, den_reg};
            quo_next = {quo_reg[PROD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift;
            quo_next = {quo_reg[PROD_W-2:0], 1'b0};
        end

        len = quo_reg[LEN_W-1:0];

        frame_cfg_next.enable       = enable_reg;
        frame_cfg_next.ax_x.kind    = AX_PLAIN;
        frame_cfg_next.ax_x.offset  = '0;
        frame_cfg_next.ax_x.divisor = LEN_W'(dw_reg);
        frame_cfg_next.ax_x.scale   = sw_reg;
        frame_cfg_next.ax_x.limit   = dw_reg;
        frame_cfg_next.ax_y.kind    = AX_PLAIN;
        frame_cfg_next.ax_y.offset  = '0;
        frame_cfg_next.ax_y.divisor = LEN_W'(dh_reg);
        frame_cfg_next.ax_y.scale   = sh_reg;
        frame_cfg_next.ax_y.limit   = dh_reg;

        if (fit_mode_reg == MODE_FIT)
        begin
            if (fill_width_reg)
            begin
                frame_cfg_next.ax_y.kind    = AX_LETTERBOX;
                frame_cfg_next.ax_y.offset  = (LEN_W'(dh_reg) - len) >> 1;
                frame_cfg_next.ax_y.divisor = len;
            end
            else
            begin
                frame_cfg_next.ax_x.kind    = AX_LETTERBOX;
                frame_cfg_next.ax_x.offset  = (LEN_W'(dw_reg) - len) >> 1;
                frame_cfg_next.ax_x.divisor = len;
            end
        end
        else
        begin
            if (fill_width_reg)
            begin
                frame_cfg_next.ax_y.kind    = AX_CROP;
                frame_cfg_next.ax_y.offset  = (len - LEN_W'(dh_reg)) >> 1;
                frame_cfg_next.ax_y.divisor = len;
            end
            else
            begin
                frame_cfg_next.ax_x.kind    = AX_CROP;
                frame_cfg_next.ax_x.offset  = (len - LEN_W'(dw_reg)) >> 1;
                frame_cfg_next.ax_x.divisor = len;
            end
        end

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_PREP: state_next = ST_CMP;
            ST_CMP:  state_next = ST_DIV;
            ST_DIV:  state_next = (cnt_reg == '0) ? ST_FIN : ST_DIV;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (cfg_write)
        begin
            state_next = ST_PREP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PREP;
            frame_cfg_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN)
            begin
                frame_cfg_reg <= frame_cfg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_PREP:
            begin
                sw_reg <= sw_c;
                sh_reg <= sh_c;
                dw_reg <= dw_c;
                dh_reg <= dh_c;
                p1_reg <= PROD_W'(sw_c) * PROD_W'(dh_c);
                p2_reg <= PROD_W'(dw_c) * PROD_W'(sh_c);
            end
            ST_CMP:
            begin
                fill_width_reg <= fill_width_next;
                enable_reg     <= enable_next;
                den_reg        <= fill_width_next ? sw_reg : sh_reg;
                quo_reg        <= fill_width_next ? p2_reg : p1_reg;
                rem_reg        <= '0;
                cnt_reg        <= CNT_W'(PROD_W - 1);
            end
            ST_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/nsfc_div_pipe.sv */
// Pipelined restoring divider that resolves one quotient bit in each stage.
`default_nettype none

module nsfc_div_pipe
    import nsfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_tag,
    input  logic [NUM_W-1:0] num,
    input  logic [LEN_W-1:0] den,
    output logic             out_valid,
    output logic             out_tag,
    output logic [Q_W-1:0]   quot
);

    logic [Q_W-1:0]   valid_reg;
    logic [Q_W-1:0]   tag_reg;
    logic [NUM_W-1:0] rem_reg  [0:Q_W-2];
    logic [Q_W-1:0]   quo_reg  [0:Q_W-1];

    logic [NUM_W-1:0] rem_src  [0:Q_W-1];
    logic [Q_W-1:0]   quo_src  [0:Q_W-1];
    logic [NUM_W-1:0] rem_next [0:Q_W-1];
    logic [Q_W-1:0]   quo_next [0:Q_W-1];

    always_comb
    begin
        logic [NUM_W-1:0] sub;
        rem_src[0] = num;
        quo_src[0] = '0;
        for (int k = 1; k < Q_W; k++)
        begin
            rem_src[k] = rem_reg[k-1];
            quo_src[k] = quo_reg[k-1];
        end
        for (int k = 0; k < Q_W; k++)
        begin
            sub = NUM_W'(den) << (Q_W - 1 - k);
            if (rem_src[k] >= sub)
            begin
                rem_next[k] = rem_src[k] - sub;
                quo_next[k] = quo_src[k] | (Q_W'(1) << (Q_W - 1 - k));
            end
            else
            begin
                rem_next[k] = rem_src[k];
                quo_next[k] = quo_src[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[Q_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= {tag_reg[Q_W-2:0], in_tag};
        for (int k = 0; k < Q_W - 1; k++)
        begin
            rem_reg[k] <= rem_next[k];
        end
        for (int k = 0; k < Q_W; k++)
        begin
            quo_reg[k] <= quo_next[k];
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_tag   = tag_reg[Q_W-1];
    assign quot      = quo_reg[Q_W-1];

endmodule

`default_nettype wire

/* hdl/nearest_scaler_fit_crop.sv */
// Top level of the nearest-neighbor scaler with letterbox fit and zoom crop.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start / busy              dst_x, dst_y
//   result    out        done (one-cycle strobe)   covered, src_x, src_y
//   config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One request is taken in every clock while busy is low.
// Each result passes through two front stages and a
// 12-stage divider that resolves one source coordinate bit per stage.
// After reset and after each configuration write, busy stays high while
// a serial 26-step divider computes the scaled length.
// The result side cannot stall, so the pipeline never holds.
`default_nettype none

module nearest_scaler_fit_crop
    import nsfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COORD_W-1:0]   dst_x,
    input  logic [COORD_W-1:0]   dst_y,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output logic                 done,
    output logic                 covered,
    output logic [COORD_W-1:0]   src_x,
    output logic [COORD_W-1:0]   src_y
);

    localparam int LATENCY = Q_W + 2;

    typedef struct packed {
        logic             cov;
        logic [LEN_W-1:0] a;
    } axis_op_t;

    frame_cfg_t       frame_cfg;
    logic             setup_active;
    logic             accept;
    axis_op_t         op_x;
    axis_op_t         op_y;

    logic             s1_valid_reg;
    logic             s1_cov_reg;
    logic [LEN_W-1:0] s1_ax_reg;
    logic [LEN_W-1:0] s1_ay_reg;
    logic             s2_valid_reg;
    logic             s2_cov_reg;
    logic [NUM_W-1:0] s2_nx_reg;
    logic [NUM_W-1:0] s2_ny_reg;

    logic             x_valid;
    logic             y_valid;
    logic             x_tag;
    logic             y_tag;
    logic [Q_W-1:0]   qx;
    logic [Q_W-1:0]   qy;

    function automatic axis_op_t axis_map(input logic [COORD_W-1:0] c, input axis_cfg_t ax);
        axis_op_t     r;
        logic [LEN_W:0] diff;
        diff  = {1'b0, LEN_W'(c)} - {1'b0, ax.offset};
        r.cov = ({1'b0, c} < ax.limit);
        r.a   = LEN_W'(c);
        case (ax.kind)
            AX_LETTERBOX:
            begin
                r.a   = diff[LEN_W-1:0];
                r.cov = r.cov && !diff[LEN_W] && (diff[LEN_W-1:0] < ax.divisor);
            end
            AX_CROP: r.a = LEN_W'(c) + ax.offset;
            default: ;
        endcase
        return r;
    endfunction

    nsfc_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .active    (setup_active),
        .frame_cfg (frame_cfg)
    );

    assign busy   = setup_active | cfg_valid;
    assign accept = start & ~busy;

    always_comb
    begin
        op_x = axis_map(dst_x, frame_cfg.ax_x);
        op_y = axis_map(dst_y, frame_cfg.ax_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cov_reg <= frame_cfg.enable & op_x.cov & op_y.cov;
        s1_ax_reg  <= op_x.a;
        s1_ay_reg  <= op_y.a;
        s2_cov_reg <= s1_cov_reg;
        s2_nx_reg  <= NUM_W'(s1_ax_reg) * NUM_W'(frame_cfg.ax_x.scale);
        s2_ny_reg  <= NUM_W'(s1_ay_reg) * NUM_W'(frame_cfg.ax_y.scale);
    end

    nsfc_div_pipe u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_tag    (s2_cov_reg),
        .num       (s2_nx_reg),
        .den       (frame_cfg.ax_x.divisor),
        .out_valid (x_valid),
        .out_tag   (x_tag),
        .quot      (qx)
    );

    nsfc_div_pipe u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_tag    (s2_cov_reg),
        .num       (s2_ny_reg),
        .den       (frame_cfg.ax_y.divisor),
        .out_valid (y_valid),
        .out_tag   (y_tag),
        .quot      (qy)
    );

    assign done    = x_valid;
    assign covered = x_valid & x_tag & y_tag;
    assign src_x   = covered ? qx : '0;
    assign src_y   = covered ? qy : '0;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, LATENCY) |-> (done == $past(start && !busy, LATENCY)))
        else $error("result strobe does not match a request accepted earlier");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        x_valid == y_valid)
        else $error("column and row divider pipelines are out of step");
`endif

endmodule

`default_nettype wire

/* verif/tb_nearest_scaler_fit_crop.sv */
// Self-checking testbench for the nearest-neighbor scaler with fit and crop modes.
`timescale 1ns / 1ps

import nsfc_pkg::*;

localparam logic [MODE_W-1:0]    MODE_OFF       = 2'd0;
localparam logic [MODE_W-1:0]    MODE_SPARE     = 2'd3;
localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;
localparam longint unsigned      CENTER_DIV     = 2;
localparam int                   MISMATCH_SHOWN = 10;

typedef struct {
    logic               cov;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
} pixel_map_t;

class pixel_map_board;
    logic [DIM_W-1:0]  src_w;
    logic [DIM_W-1:0]  src_h;
    logic [DIM_W-1:0]  dst_w;
    logic [DIM_W-1:0]  dst_h;
    logic [MODE_W-1:0] mode;
    pixel_map_t        expected_maps[$];
    int                mismatches;

    function new();
        src_w      = 13'd640;
        src_h      = 13'd480;
        dst_w      = 13'd640;
        dst_h      = 13'd480;
        mode       = MODE_FIT;
        mismatches = 0;
    endfunction

    function longint unsigned clamp_dim(logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? longint'(MAX_DIM) : longint'(v);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        case (idx)
            REG_SRC_WIDTH:  src_w = data;
            REG_SRC_HEIGHT: src_h = data;
            REG_DST_WIDTH:  dst_w = data;
            REG_DST_HEIGHT: dst_h = data;
            REG_FIT_MODE:   mode  = data[MODE_W-1:0];
            default: ;
        endcase
    endfunction

    function pixel_map_t map_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        longint unsigned sw, sh, dw, dh, px, py, span, offs, sx, sy;
        logic            wide;
        pixel_map_t      m;
        sw    = clamp_dim(src_w);
        sh    = clamp_dim(src_h);
        dw    = clamp_dim(dst_w);
        dh    = clamp_dim(dst_h);
        px    = 64'(x);
        py    = 64'(y);
        sx    = 0;
        sy    = 0;
        m.cov = 1'b0;
        if ((mode == MODE_FIT || mode == MODE_ZOOM) && sw != 0 && sh != 0 &&
            dw != 0 && dh != 0 && px < dw && py < dh)
        begin
            wide = (sw * dh) > (dw * sh);
            if (mode == MODE_FIT)
            begin
                if (wide)
                begin
                    span = (sh * dw) / sw;
                    offs = (dh - span) / CENTER_DIV;
                    if (span != 0 && py >= offs && py < offs + span)
                    begin
                        m.cov = 1'b1;
                        sx    = (px * sw) / dw;
                        sy    = ((py - offs) * sh) / span;
                    end
                end
                else
                begin
                    span = (sw * dh) / sh;
                    offs = (dw - span) / CENTER_DIV;
                    if (span != 0 && px >= offs && px < offs + span)
                    begin
                        m.cov = 1'b1;
                        sx    = ((px - offs) * sw) / span;
                        sy    = (py * sh) / dh;
                    end
                end
            end
            else
            begin
                m.cov = 1'b1;
                if (wide)
                begin
                    span = (sw * dh) / sh;
                    offs = (span - dw) / CENTER_DIV;
                    sx   = ((px + offs) * sw) / span;
                    sy   = (py * sh) / dh;
                end
                else
                begin
                    span = (sh * dw) / sw;
                    offs = (span - dh) / CENTER_DIV;
                    sx   = (px * sw) / dw;
                    sy   = ((py + offs) * sh) / span;
                end
            end
        end
        m.sx = m.cov ? sx[COORD_W-1:0] : '0;
        m.sy = m.cov ? sy[COORD_W-1:0] : '0;
        return m;
    endfunction

    function void note_request(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        expected_maps.push_back(map_pixel(x, y));
    endfunction

    function void check_result(logic cov, logic [COORD_W-1:0] sx,
                               logic [COORD_W-1:0] sy);
        pixel_map_t want;
        if (expected_maps.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
                $display("unexpected result: covered=%0d src_x=%0d src_y=%0d",
                         cov, sx, sy);
            return;
        end
        want = expected_maps.pop_front();
        if (cov !== want.cov || sx !== want.sx || sy !== want.sy)
        begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
                $display({"mismatch: expected covered=%0d src_x=%0d src_y=%0d, ",
                          "got covered=%0d src_x=%0d src_y=%0d"},
                         want.cov, want.sx, want.sy, cov, sx, sy);
        end
    endfunction
endclass

module tb_nearest_scaler_fit_crop;

    localparam int RESULT_LATENCY = 14;
    localparam int QUIET_LIMIT    = 2000;
    localparam int RANDOM_ITEMS   = 480;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [COORD_W-1:0]   dst_x;
    logic [COORD_W-1:0]   dst_y;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 done;
    logic                 covered;
    logic [COORD_W-1:0]   src_x;
    logic [COORD_W-1:0]   src_y;

    pixel_map_board board;
    int             quiet_cycles;
    int             sent;

    nearest_scaler_fit_crop dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .dst_x     (dst_x),
        .dst_y     (dst_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .covered   (covered),
        .src_x     (src_x),
        .src_y     (src_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_reg(cfg_index, cfg_data);
            if (start && !busy)
                board.note_request(dst_x, dst_y);
            if (done)
                board.check_result(covered, src_x, src_y);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("nearest_scaler_fit_crop test failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(int dim);
        int r;
        r = $urandom_range(99, 0);
        if (dim > 0 && r < 75)
            return COORD_W'($urandom_range(dim - 1, 0));
        else if (r < 80)
            return '0;
        else if (dim > 0 && r < 86)
            return COORD_W'(dim - 1);
        else if (r < 91)
            return COORD_W'(dim);
        else
            return COORD_W'($urandom);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99, 0);
        if (r < 3)
            return '0;
        else if (r < 6)
            return DIM_W'($urandom_range(8191, MAX_DIM + 1));
        else if (r < 10)
            return DIM_W'(MAX_DIM);
        else if (r < 14)
            return DIM_W'(1);
        else if (r < 34)
            return DIM_W'($urandom_range(16, 1));
        else
            return DIM_W'($urandom_range(MAX_DIM, 1));
    endfunction

    task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input int gap);
        start <= 1'b1;
        dst_x <= x;
        dst_y <= y;
        do
            @(posedge clk);
        while (busy);
        sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
            begin
                dst_x <= COORD_W'($urandom);
                dst_y <= COORD_W'($urandom);
                @(posedge clk);
            end
        end
    endtask

    task automatic drain_requests();
        start <= 1'b0;
        while (board.expected_maps.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY) @(posedge clk);
    endtask

    task automatic load_frame(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                              input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh,
                              input logic [DIM_W-1:0] mode_word, input bit spare);
        logic [CFG_IDX_W-1:0] idx_list [6];
        logic [DIM_W-1:0]     val_list [6];
        int                   count;
        drain_requests();
        idx_list[0] = REG_SRC_WIDTH;  val_list[0] = sw;
        idx_list[1] = REG_SRC_HEIGHT; val_list[1] = sh;
        idx_list[2] = REG_DST_WIDTH;  val_list[2] = dw;
        idx_list[3] = REG_DST_HEIGHT; val_list[3] = dh;
        idx_list[4] = REG_FIT_MODE;   val_list[4] = mode_word;
        idx_list[5] = CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_FIT_MODE + 1));
        val_list[5] = DIM_W'($urandom);
        count = spare ? 6 : 5;
        for (int i = 0; i < count; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase();
        logic [DIM_W-1:0]  sw, sh, dw, dh, mode_word;
        logic [MODE_W-1:0] mode;
        int                r, n, cw, ch;
        bit                burst;
        sw = pick_dim();
        sh = pick_dim();
        dw = pick_dim();
        dh = pick_dim();
        if ($urandom_range(9, 0) == 0)
        begin
            dw = sw;
            dh = sh;
        end
        r = $urandom_range(99, 0);
        if (r < 8)
            mode = MODE_OFF;
        else if (r < 12)
            mode = MODE_SPARE;
        else if (r < 56)
            mode = MODE_FIT;
        else
            mode = MODE_ZOOM;
        mode_word = {($urandom_range(1, 0) == 1) ? 11'($urandom) : 11'd0, mode};
        load_frame(sw, sh, dw, dh, mode_word, $urandom_range(7, 0) == 0);
        cw    = int'(board.clamp_dim(dw));
        ch    = int'(board.clamp_dim(dh));
        n     = $urandom_range(40, 10);
        burst = ($urandom_range(3, 0) == 0);
        repeat (n)
            send_pixel(pick_coord(cw), pick_coord(ch), burst ? 0 : pick_gap());
    endtask

    initial
    begin
        int leftover;
        board        = new();
        quiet_cycles = 0;
        sent         = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        dst_x     <= '0;
        dst_y     <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: equal aspect, so the height is filled.
        send_pixel(12'd0, 12'd0, pick_gap());
        send_pixel(12'd639, 12'd479, pick_gap());
        send_pixel(12'd640, 12'd0, pick_gap());
        send_pixel(12'd4095, 12'd4095, pick_gap());

        load_frame(13'd640, 13'd480, 13'd640, 13'd480, MODE_OFF, 1'b0);
        send_pixel(12'd320, 12'd240, 0);
        load_frame(13'd640, 13'd480, 13'd640, 13'd480, MODE_SPARE, 1'b1);
        send_pixel(12'd320, 12'd240, 0);

        // Wide source letterboxed top and bottom, then cropped left and right.
        load_frame(13'd1920, 13'd1080, 13'd640, 13'd480, MODE_FIT, 1'b0);
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'd0, 12'd240, 0);
        send_pixel(12'd639, 12'd479, 0);
        load_frame(13'd1920, 13'd1080, 13'd640, 13'd480, MODE_ZOOM, 1'b0);
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'd639, 12'd479, 0);

        // Tall source letterboxed left and right, then cropped top and bottom.
        load_frame(13'd480, 13'd640, 13'd640, 13'd480, MODE_FIT, 1'b0);
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'd320, 12'd240, 0);
        send_pixel(12'd639, 12'd479, 0);
        load_frame(13'd480, 13'd640, 13'd640, 13'd480, MODE_ZOOM, 1'b0);
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'd639, 12'd479, 0);

        // The scaled height floors to zero and nothing is covered.
        load_frame(13'd4096, 13'd1, 13'd100, 13'd100, MODE_FIT, 1'b0);
        send_pixel(12'd50, 12'd50, 0);

        load_frame(13'd0, 13'd480, 13'd640, 13'd480, MODE_FIT, 1'b0);
        send_pixel(12'd0, 12'd0, 0);

        // Oversized sizes are taken as the maximum dimension.
        load_frame(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, MODE_FIT, 1'b0);
        send_pixel(12'd4095, 12'd4095, 0);
        send_pixel(12'd0, 12'd0, 0);

        load_frame(13'd1, 13'd1, 13'd1, 13'd1, MODE_ZOOM, 1'b0);
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'd1, 12'd0, 0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
            random_phase();

        drain_requests();
        repeat (4) @(posedge clk);
        leftover = board.expected_maps.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);
        if (board.mismatches == 0 && leftover == 0)
            $display("nearest_scaler_fit_crop test passed");
        else
            $display("nearest_scaler_fit_crop test failed");
        $finish;
    end

endmodule
